// ===== rtl/mhpq_pkg.sv =====
// Shared types and codes for the min-heap priority queue.
// Used by the top level and by the shared compare unit; depends on nothing.
package mhpq_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_POP    = 2'd1,
    OP_CHANGE = 2'd2
  } op_e_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] weight;
  } entry_t;

  typedef struct packed {
    logic w_lt;
    logic ord_lt;
    logic id_eq;
  } cmp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_POP_RD0,
    ST_POP_RDL,
    ST_POP_LAST,
    ST_CHG_RD,
    ST_CHG_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_L,
    ST_DN_R,
    ST_DN_SEL,
    ST_DN_DEC,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/mhpq_cmp.sv =====
// Shared compare unit of the min-heap priority queue.
// Compares two heap entries by weight, by weight then id, and by id; uses mhpq_pkg.
module mhpq_cmp import mhpq_pkg::*; (
  input  entry_t   a,
  input  entry_t   b,
  output cmp_res_t res
);

  logic w_eq;

  assign w_eq       = (a.weight == b.weight);
  assign res.w_lt   = (a.weight < b.weight);
  assign res.ord_lt = (a.weight < b.weight) || (w_eq && (a.id < b.id));
  assign res.id_eq  = (a.id == b.id);

endmodule

// ===== rtl/min_heap_priority_queue.sv =====
// Top level of the min-heap priority queue: sequencer, heap memory and registers.
// Depends on mhpq_pkg and on the shared compare unit mhpq_cmp.
//
// A beat is taken when start is high and busy is low; busy then stays high until the
// result has been shown on the out_ ports for exactly one cycle with out_valid high,
// and the receiver cannot hold it off. All work goes through one heap memory with one
// read and one write per cycle. An add or a change first scans the stored ids; an add
// then sifts up, and a change tests its parent, if it has one, before sifting up or down.
// A pop fetches the root and the last entry in ST_POP_RD0, ST_POP_RDL and ST_POP_LAST,
// then sifts the last entry down. The result is then shown in ST_DONE.
module min_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY = 64,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [15:0]        in_item_id,
  input  logic signed [31:0] in_item_weight,
  output logic               out_valid,
  output logic               out_ok,
  output logic [15:0]        out_popped_id,
  output logic signed [31:0] out_popped_weight,
  output logic [CNT_W-1:0]   out_heap_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CH_W  = IDX_W + 2;

  state_t             state_r, state_nxt;
  op_e_t              op_r, op_nxt;
  entry_t             cur_r, cur_nxt;
  entry_t             child_r, child_nxt;
  entry_t             pop_r, pop_nxt;
  entry_t             rdata_r;
  logic [IDX_W-1:0]   child_idx_r, child_idx_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic               ok_r, ok_nxt;

  entry_t             mem [CAPACITY];
  logic               mem_we;
  logic [IDX_W-1:0]   waddr, raddr;
  entry_t             wdata;

  entry_t             op_a, op_b;
  cmp_res_t           res;

  logic [IDX_W-1:0]   par_idx;
  logic [CH_W-1:0]    left_w, right_w, cnt_ext;
  logic [CNT_W-1:0]   scan_m1, cnt_m1;
  logic               l_in, r_in, found, scan_end, not_full;

  assign par_idx  = (pos_r - IDX_W'(1)) >> 1;
  assign left_w   = {1'b0, pos_r, 1'b1};
  assign right_w  = left_w + CH_W'(1);
  assign cnt_ext  = CH_W'(count_r);
  assign l_in     = (left_w < cnt_ext);
  assign r_in     = (right_w < cnt_ext);
  assign scan_m1  = scan_r - CNT_W'(1);
  assign cnt_m1   = count_r - CNT_W'(1);
  assign found    = cmp_v_r && res.id_eq;
  assign scan_end = (scan_r == count_r);
  assign not_full = (count_r < CNT_W'(CAPACITY));

  always_comb begin
    op_a = cur_r;
    op_b = rdata_r;
    unique case (state_r)
      ST_SRCH: begin
        op_a = rdata_r;
        op_b = cur_r;
      end
      ST_DN_SEL: begin
        op_a = child_r;
        op_b = rdata_r;
      end
      ST_DN_DEC: begin
        op_a = cur_r;
        op_b = child_r;
      end
      default: begin
        op_a = cur_r;
        op_b = rdata_r;
      end
    endcase
  end

  mhpq_cmp u_cmp (
    .a   (op_a),
    .b   (op_b),
    .res (res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_op)
            OP_ADD, OP_CHANGE: state_nxt = ST_SRCH;
            OP_POP:            state_nxt = (count_r == '0) ? ST_DONE : ST_POP_RD0;
            default:           state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SRCH: begin
        if (found) begin
          state_nxt = (op_r == OP_CHANGE) ? ST_CHG_RD : ST_DONE;
        end else if (scan_end) begin
          state_nxt = (op_r == OP_ADD && not_full) ? ST_UP_RD : ST_DONE;
        end
      end
      ST_POP_RD0:  state_nxt = ST_POP_RDL;
      ST_POP_RDL:  state_nxt = ST_POP_LAST;
      ST_POP_LAST: state_nxt = ST_DN_L;
      ST_CHG_RD:   state_nxt = (pos_r == '0) ? ST_DN_L : ST_CHG_CMP;
      ST_CHG_CMP:  state_nxt = res.w_lt ? ST_UP_RD : ST_DN_L;
      ST_UP_RD:    state_nxt = (pos_r == '0) ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP:   state_nxt = res.w_lt ? ST_UP_RD : ST_DONE;
      ST_DN_L:     state_nxt = l_in ? ST_DN_R : ST_DONE;
      ST_DN_R:     state_nxt = r_in ? ST_DN_SEL : ST_DN_DEC;
      ST_DN_SEL:   state_nxt = ST_DN_DEC;
      ST_DN_DEC:   state_nxt = res.w_lt ? ST_DONE : ST_DN_L;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    raddr  = '0;
    mem_we = 1'b0;
    waddr  = pos_r;
    wdata  = cur_r;
    unique case (state_r)
      ST_SRCH:     raddr = scan_r[IDX_W-1:0];
      ST_POP_RD0:  raddr = '0;
      ST_POP_RDL:  raddr = cnt_m1[IDX_W-1:0];
      ST_CHG_RD:   raddr = par_idx;
      ST_CHG_CMP: begin
        if (res.w_lt) begin
          mem_we = 1'b1;
          wdata  = rdata_r;
        end
      end
      ST_UP_RD: begin
        raddr = par_idx;
        if (pos_r == '0) begin
          mem_we = 1'b1;
        end
      end
      ST_UP_CMP: begin
        mem_we = 1'b1;
        wdata  = res.w_lt ? rdata_r : cur_r;
      end
      ST_DN_L: begin
        raddr = left_w[IDX_W-1:0];
        if (!l_in) begin
          mem_we = 1'b1;
        end
      end
      ST_DN_R:     raddr = right_w[IDX_W-1:0];
      ST_DN_DEC: begin
        mem_we = 1'b1;
        wdata  = res.w_lt ? cur_r : child_r;
      end
      default: begin
        raddr  = '0;
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    cur_nxt       = cur_r;
    child_nxt     = child_r;
    child_idx_nxt = child_idx_r;
    pop_nxt       = pop_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    cmp_v_nxt     = cmp_v_r;
    ok_nxt        = ok_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt        = op_e_t'(in_op);
          cur_nxt.id     = in_item_id;
          cur_nxt.weight = in_item_weight;
          scan_nxt      = '0;
          cmp_v_nxt     = 1'b0;
          ok_nxt        = 1'b0;
          pop_nxt       = '0;
        end
      end
      ST_SRCH: begin
        if (found) begin
          pos_nxt = scan_m1[IDX_W-1:0];
          ok_nxt  = (op_r == OP_CHANGE);
        end else if (scan_end) begin
          if (op_r == OP_ADD && not_full) begin
            pos_nxt   = count_r[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
            ok_nxt    = 1'b1;
          end
        end else begin
          scan_nxt  = scan_r + CNT_W'(1);
          cmp_v_nxt = 1'b1;
        end
      end
      ST_POP_RDL: begin
        pop_nxt = rdata_r;
        ok_nxt  = 1'b1;
      end
      ST_POP_LAST: begin
        cur_nxt   = rdata_r;
        count_nxt = cnt_m1;
        pos_nxt   = '0;
      end
      ST_CHG_CMP, ST_UP_CMP: begin
        if (res.w_lt) begin
          pos_nxt = par_idx;
        end
      end
      ST_DN_R: begin
        child_nxt     = rdata_r;
        child_idx_nxt = left_w[IDX_W-1:0];
      end
      ST_DN_SEL: begin
        if (!res.ord_lt) begin
          child_nxt     = rdata_r;
          child_idx_nxt = right_w[IDX_W-1:0];
        end
      end
      ST_DN_DEC: begin
        if (!res.w_lt) begin
          pos_nxt = child_idx_r;
        end
      end
      default: begin
        ok_nxt = ok_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    cur_r       <= cur_nxt;
    child_r     <= child_nxt;
    child_idx_r <= child_idx_nxt;
    pop_r       <= pop_nxt;
    pos_r       <= pos_nxt;
    scan_r      <= scan_nxt;
    ok_r        <= ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = (state_r == ST_DONE);
  assign out_ok            = ok_r;
  assign out_popped_id     = pop_r.id;
  assign out_popped_weight = pop_r.weight;
  assign out_heap_count    = count_r;

endmodule

// ===== rtl/mhpq_chk.sv =====
// Port-level checker for the min-heap priority queue, bound to the top level below.
// Watches only the top-level ports; depends on nothing else.
module mhpq_chk #(
  parameter int CAPACITY = 64,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic               out_ok,
  input logic [15:0]        out_popped_id,
  input logic signed [31:0] out_popped_weight,
  input logic [CNT_W-1:0]   out_heap_count
);

  a_take_sets_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("A beat was taken but the block did not become busy.");

  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("The result strobe lasted more than one cycle or busy stayed high.");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heap_count <= CNT_W'(CAPACITY))
    else $error("The reported count exceeds the capacity.");

  a_fail_zeroes : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_popped_id == 16'd0 && out_popped_weight == 32'sd0)
    else $error("A failed operation reported a non-zero popped entry.");

  a_busy_on_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("A result was shown while the block was idle.");

endmodule

bind min_heap_priority_queue mhpq_chk #(.CAPACITY(CAPACITY)) u_mhpq_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_ok            (out_ok),
  .out_popped_id     (out_popped_id),
  .out_popped_weight (out_popped_weight),
  .out_heap_count    (out_heap_count)
);
